@@ sv/lfe_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfe_pkg
// Shared constants, codes and types of the addressable LED frame encoder.
// ----------------------------------------------------------------------------
package lfe_pkg;

	// Size of the colour store
	localparam int LED_COUNT = 64;
	localparam int IDX_W     = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;

	// Field widths
	localparam int REQ_W   = 2;
	localparam int LIDX_W  = 12;
	localparam int COLOR_W = 24;
	localparam int BYTE_W  = 8;

	// LED count held one bit wider than an LED index field, so 4096 fits
	localparam logic [LIDX_W:0] LED_LIMIT = (LIDX_W + 1)'(LED_COUNT);

	// Line bytes per LED
	localparam int BITS_PER_LED = 24;
	localparam int CNT_W        = $clog2(BITS_PER_LED);
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(BITS_PER_LED - 1);

	// Configuration register indexes and reset values
	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] CFG_ONE_PATTERN  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_ZERO_PATTERN = 1'b1;
	localparam logic [BYTE_W-1:0] ONE_PATTERN_RST  = 8'hF8;
	localparam logic [BYTE_W-1:0] ZERO_PATTERN_RST = 8'hC0;

	// Result kinds
	localparam logic KIND_COLOR = 1'b0;
	localparam logic KIND_LINE  = 1'b1;

	typedef enum logic [REQ_W-1:0] {
		REQ_WRITE = 2'd0,
		REQ_READ  = 2'd1,
		REQ_CLEAR = 2'd2,
		REQ_EMIT  = 2'd3
	} req_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FILL,
		ST_RD_WAIT,
		ST_RD_RESP,
		ST_EM_WAIT,
		ST_EMIT
	} state_t;

	// Access to the colour store from the controller
	typedef struct packed {
		logic               wr_en;
		logic [IDX_W-1:0]   wr_addr;
		logic [COLOR_W-1:0] wr_data;
		logic               rd_en;
		logic [IDX_W-1:0]   rd_addr;
		logic               clr_all;
	} store_req_t;

	// Reorder packed RGB into line order: green, red, blue
	function automatic logic [COLOR_W-1:0] to_grb(input logic [COLOR_W-1:0] rgb);
		to_grb = {rgb[15:8], rgb[23:16], rgb[7:0]};
	endfunction

endpackage

@@ sv/lfe_store.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfe_store
// Colour store: one synchronous RAM entry per LED with a registered read port,
// and a valid bit per entry so reset and clear-all take effect at once.
// ----------------------------------------------------------------------------
module lfe_store (
	input  logic                        clk,
	input  logic                        arst_n,
	input  lfe_pkg::store_req_t         req,
	output logic [lfe_pkg::COLOR_W-1:0] rd_color
);

	logic [lfe_pkg::COLOR_W-1:0]   mem [lfe_pkg::LED_COUNT];
	logic [lfe_pkg::LED_COUNT-1:0] vld_q;
	logic [lfe_pkg::COLOR_W-1:0]   rd_data_q;
	logic                          rd_vld_q;

	// Write port and registered read port
	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem[req.wr_addr] <= req.wr_data;
		end
		if (req.rd_en) begin
			rd_data_q <= mem[req.rd_addr];
		end
	end

	// Track which entries hold written data; clear drops them all
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (req.clr_all) begin
				vld_q <= '0;
			end else if (req.wr_en) begin
				vld_q[req.wr_addr] <= 1'b1;
			end
			if (req.rd_en) begin
				rd_vld_q <= vld_q[req.rd_addr];
			end
		end
	end

	// An entry never written since the last clear reads as off
	assign rd_color = rd_vld_q ? rd_data_q : '0;

endmodule

@@ sv/lfe_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfe_ctrl
// Request sequencer: walks range writes through the store, issues reads and clears,
// and serialises one LED into 24 line bytes.
// ----------------------------------------------------------------------------
module lfe_ctrl (
	input  logic                        clk,
	input  logic                        arst_n,
	// request channel
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [lfe_pkg::REQ_W-1:0]   req_type,
	input  logic [lfe_pkg::LIDX_W-1:0]  range_start,
	input  logic [lfe_pkg::LIDX_W-1:0]  range_stop,
	input  logic [lfe_pkg::LIDX_W-1:0]  led_index,
	input  logic [lfe_pkg::COLOR_W-1:0] color,
	// result channel
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic                        result_kind,
	output logic [lfe_pkg::COLOR_W-1:0] read_color,
	output logic [lfe_pkg::BYTE_W-1:0]  line_byte,
	output logic                        last,
	// line patterns
	input  logic [lfe_pkg::BYTE_W-1:0]  one_pattern,
	input  logic [lfe_pkg::BYTE_W-1:0]  zero_pattern,
	// colour store
	output lfe_pkg::store_req_t         store_req,
	input  logic [lfe_pkg::COLOR_W-1:0] rd_color
);

	lfe_pkg::state_t state_q, state_d;

	logic [lfe_pkg::IDX_W-1:0]   cursor_q;
	logic [lfe_pkg::IDX_W-1:0]   stop_q;
	logic [lfe_pkg::COLOR_W-1:0] fill_color_q;
	logic                        in_range_q;
	logic [lfe_pkg::COLOR_W-1:0] color_q;
	logic [lfe_pkg::COLOR_W-1:0] grb_q;
	logic [lfe_pkg::CNT_W-1:0]   cnt_q;

	logic in_acc;
	logic out_acc;
	logic fill_ok;
	logic idx_ok;
	logic fill_end;
	logic [lfe_pkg::COLOR_W-1:0] fetched;

	// Request decode
	assign in_acc   = in_valid && !in_stall;
	assign out_acc  = out_valid && !out_stall;
	assign fill_ok  = ({1'b0, range_stop} < lfe_pkg::LED_LIMIT) && (range_start <= range_stop);
	assign idx_ok   = ({1'b0, led_index} < lfe_pkg::LED_LIMIT);
	assign fill_end = (cursor_q == stop_q);
	assign fetched  = in_range_q ? rd_color : '0;

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			lfe_pkg::ST_IDLE: begin
				if (in_valid) begin
					case (lfe_pkg::req_t'(req_type))
						lfe_pkg::REQ_WRITE: if (fill_ok) state_d = lfe_pkg::ST_FILL;
						lfe_pkg::REQ_READ:  state_d = lfe_pkg::ST_RD_WAIT;
						lfe_pkg::REQ_EMIT:  state_d = lfe_pkg::ST_EM_WAIT;
						default:            state_d = lfe_pkg::ST_IDLE;
					endcase
				end
			end
			lfe_pkg::ST_FILL:    if (fill_end) state_d = lfe_pkg::ST_IDLE;
			lfe_pkg::ST_RD_WAIT: state_d = lfe_pkg::ST_RD_RESP;
			lfe_pkg::ST_RD_RESP: if (!out_stall) state_d = lfe_pkg::ST_IDLE;
			lfe_pkg::ST_EM_WAIT: state_d = lfe_pkg::ST_EMIT;
			lfe_pkg::ST_EMIT: begin
				if (!out_stall && cnt_q == lfe_pkg::CNT_LAST) state_d = lfe_pkg::ST_IDLE;
			end
			default: state_d = lfe_pkg::ST_IDLE;
		endcase
	end

	// Outputs
	always_comb begin
		in_stall          = (state_q != lfe_pkg::ST_IDLE);
		out_valid         = 1'b0;
		result_kind       = lfe_pkg::KIND_COLOR;
		read_color        = '0;
		line_byte         = '0;
		last              = 1'b0;
		store_req.wr_en   = 1'b0;
		store_req.wr_addr = cursor_q;
		store_req.wr_data = fill_color_q;
		store_req.rd_en   = 1'b0;
		store_req.rd_addr = led_index[lfe_pkg::IDX_W-1:0];
		store_req.clr_all = 1'b0;
		case (state_q)
			lfe_pkg::ST_IDLE: begin
				store_req.rd_en   = in_valid && (req_type == lfe_pkg::REQ_READ ||
				                                 req_type == lfe_pkg::REQ_EMIT);
				store_req.clr_all = in_valid && (req_type == lfe_pkg::REQ_CLEAR);
			end
			lfe_pkg::ST_FILL: begin
				store_req.wr_en = 1'b1;
			end
			lfe_pkg::ST_RD_RESP: begin
				out_valid  = 1'b1;
				read_color = color_q;
				last       = 1'b1;
			end
			lfe_pkg::ST_EMIT: begin
				out_valid   = 1'b1;
				result_kind = lfe_pkg::KIND_LINE;
				line_byte   = grb_q[lfe_pkg::COLOR_W-1] ? one_pattern : zero_pattern;
				last        = (cnt_q == lfe_pkg::CNT_LAST);
			end
			default: begin
				out_valid = 1'b0;
			end
		endcase
	end

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lfe_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Datapath: capture the request, advance the fill cursor, shift the bits out
	always_ff @(posedge clk) begin
		if (in_acc) begin
			cursor_q     <= range_start[lfe_pkg::IDX_W-1:0];
			stop_q       <= range_stop[lfe_pkg::IDX_W-1:0];
			fill_color_q <= color;
			in_range_q   <= idx_ok;
		end else if (state_q == lfe_pkg::ST_FILL) begin
			cursor_q <= cursor_q + 1'b1;
		end
		if (state_q == lfe_pkg::ST_RD_WAIT) begin
			color_q <= fetched;
		end
		if (state_q == lfe_pkg::ST_EM_WAIT) begin
			grb_q <= lfe_pkg::to_grb(fetched);
			cnt_q <= '0;
		end else if (state_q == lfe_pkg::ST_EMIT && out_acc) begin
			grb_q <= {grb_q[lfe_pkg::COLOR_W-2:0], 1'b0};
			cnt_q <= cnt_q + 1'b1;
		end
	end

endmodule

@@ sv/addressable_led_frame_encoder.sv @@
`timescale 1ns / 1ps
// A request beat issues the store read; RD_WAIT or EM_WAIT registers the fetched colour,
// and the read answer or the first line byte is then offered. Emit sends 24 bytes one a
// cycle while out_stall is low; a range write takes its request beat, then one store entry
// a cycle; a clear is taken with its request beat; one request at a time.
// Reset: every LED reads as off at once through per-entry valid bits (no sweep);
// one_pattern returns to 0xF8 and zero_pattern to 0xC0.
// ----------------------------------------------------------------------------
// addressable_led_frame_encoder
// LED colour store with range write, read, clear and line-code emit requests.
// ----------------------------------------------------------------------------
module addressable_led_frame_encoder (
	input  logic                          clk,
	input  logic                          arst_n,
	// request channel
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [lfe_pkg::REQ_W-1:0]     req_type,
	input  logic [lfe_pkg::LIDX_W-1:0]    range_start,
	input  logic [lfe_pkg::LIDX_W-1:0]    range_stop,
	input  logic [lfe_pkg::LIDX_W-1:0]    led_index,
	input  logic [lfe_pkg::COLOR_W-1:0]   color,
	// result channel
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic                          result_kind,
	output logic [lfe_pkg::COLOR_W-1:0]   read_color,
	output logic [lfe_pkg::BYTE_W-1:0]    line_byte,
	output logic                          last,
	// configuration write channel
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [lfe_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [lfe_pkg::BYTE_W-1:0]    cfg_data
);

	logic [lfe_pkg::BYTE_W-1:0]  one_pattern_q;
	logic [lfe_pkg::BYTE_W-1:0]  zero_pattern_q;
	lfe_pkg::store_req_t         store_req;
	logic [lfe_pkg::COLOR_W-1:0] rd_color;

	// Configuration registers take a beat every cycle
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			one_pattern_q  <= lfe_pkg::ONE_PATTERN_RST;
			zero_pattern_q <= lfe_pkg::ZERO_PATTERN_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				lfe_pkg::CFG_ONE_PATTERN:  one_pattern_q  <= cfg_data;
				lfe_pkg::CFG_ZERO_PATTERN: zero_pattern_q <= cfg_data;
				default:                   one_pattern_q  <= one_pattern_q;
			endcase
		end
	end

	lfe_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.req_type     (req_type),
		.range_start  (range_start),
		.range_stop   (range_stop),
		.led_index    (led_index),
		.color        (color),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.result_kind  (result_kind),
		.read_color   (read_color),
		.line_byte    (line_byte),
		.last         (last),
		.one_pattern  (one_pattern_q),
		.zero_pattern (zero_pattern_q),
		.store_req    (store_req),
		.rd_color     (rd_color)
	);

	lfe_store u_store (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (store_req),
		.rd_color (rd_color)
	);

	// One request at a time: no request beat while a result is offered
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |-> !out_valid)
		else $error("request accepted while a result is pending");

	// An emit keeps going until its last byte
	a_emit_continues: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_stall && !last) |=> (out_valid && result_kind))
		else $error("line byte stream broke before its last byte");

	// A read answer is a single, last beat with no line byte
	a_read_single: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !result_kind) |-> (last && line_byte == '0))
		else $error("malformed read answer");

	// Line bytes carry no colour
	a_line_no_color: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && result_kind) |-> (read_color == '0))
		else $error("line byte carries a colour");

endmodule

@@ verif/addressable_led_frame_encoder_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// addressable_led_frame_encoder_tb
// Self-checking bench for the LED frame encoder. A directed table covers reset
// contents, index extremes, ignored range writes, clear and emit. Random
// request mixes follow under several line-code patterns. Every result beat is
// compared against a typed answer from the table or an in-bench colour store and line encoder.
// ----------------------------------------------------------------------------
module addressable_led_frame_encoder_tb;

	import lfe_pkg::*;

	localparam int ROWS         = 25;
	localparam int PHASES       = 5;
	localparam int PHASE_ITEMS  = 57;
	localparam int SETTLE_GAP   = LED_COUNT + 16;
	localparam int STALL_LIMIT  = 4000;

	typedef struct packed {
		req_t               req;
		logic [LIDX_W-1:0]  start;
		logic [LIDX_W-1:0]  stop;
		logic [LIDX_W-1:0]  idx;
		logic [COLOR_W-1:0] col;
		logic               typed;
		logic [COLOR_W-1:0] want;
	} led_request_t;

	typedef struct packed {
		logic               kind;
		logic [COLOR_W-1:0] rgb;
		logic [BYTE_W-1:0]  lbyte;
		logic               last;
	} led_beat_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 in_valid = 1'b0;
	logic                 in_stall;
	logic [REQ_W-1:0]     req_type = '0;
	logic [LIDX_W-1:0]    range_start = '0;
	logic [LIDX_W-1:0]    range_stop = '0;
	logic [LIDX_W-1:0]    led_index = '0;
	logic [COLOR_W-1:0]   color = '0;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	logic                 result_kind;
	logic [COLOR_W-1:0]   read_color;
	logic [BYTE_W-1:0]    line_byte;
	logic                 last;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [BYTE_W-1:0]    cfg_data = '0;

	// Bench copy of the colour store and the line patterns
	logic [COLOR_W-1:0] led_colors [LED_COUNT];
	logic [BYTE_W-1:0]  one_pat = ONE_PATTERN_RST;
	logic [BYTE_W-1:0]  zero_pat = ZERO_PATTERN_RST;
	led_beat_t          due_beats [$];
	led_request_t       directed_rows [ROWS];
	int                 error_count = 0;
	int                 quiet_cycles = 0;
	bit                 steady = 1'b0;

	addressable_led_frame_encoder i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.req_type    (req_type),
		.range_start (range_start),
		.range_stop  (range_stop),
		.led_index   (led_index),
		.color       (color),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.result_kind (result_kind),
		.read_color  (read_color),
		.line_byte   (line_byte),
		.last        (last),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	always #10 clk = ~clk;

	function automatic bit take_gap();
		return !steady && ($urandom_range(99) < 30);
	endfunction

	// Apply one accepted request to the store and queue the beats it owes
	task automatic encode_request(input led_request_t item);
		logic [COLOR_W-1:0] c;
		logic [COLOR_W-1:0] grb;
		int k;
		c = (item.idx < LED_COUNT) ? led_colors[item.idx[IDX_W-1:0]] : '0;
		case (item.req)
			REQ_WRITE: begin
				if (item.stop < LED_COUNT)
					for (k = item.start; k <= item.stop; k++)
						led_colors[k] = item.col;
			end
			REQ_READ: begin
				due_beats.push_back('{KIND_COLOR, c, '0, 1'b1});
			end
			REQ_CLEAR: begin
				for (k = 0; k < LED_COUNT; k++)
					led_colors[k] = '0;
			end
			default: begin
				// line order is green, red, blue, each MSB first
				grb = {c[15:8], c[23:16], c[7:0]};
				for (k = 0; k < BITS_PER_LED; k++)
					due_beats.push_back('{KIND_LINE, '0,
						grb[BITS_PER_LED-1-k] ? one_pat : zero_pat,
						k == BITS_PER_LED - 1});
			end
		endcase
	endtask

	// Present one request beat, with random gaps ahead of it
	task automatic drive_request(input led_request_t item);
		while (take_gap()) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid    <= 1'b1;
		req_type    <= item.req;
		range_start <= item.start;
		range_stop  <= item.stop;
		led_index   <= item.idx;
		color       <= item.col;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		if (item.typed)
			due_beats.push_back('{KIND_COLOR, item.want, '0, 1'b1});
		else
			encode_request(item);
	endtask

	// Hold off the sender until every owed beat has arrived, then idle a while
	task automatic settle(input int extra);
		in_valid <= 1'b0;
		@(posedge clk);
		while (due_beats.size() != 0)
			@(posedge clk);
		repeat (extra) @(posedge clk);
	endtask

	task automatic set_patterns(input logic [BYTE_W-1:0] one_val,
			input logic [BYTE_W-1:0] zero_val);
		cfg_valid <= 1'b1;
		cfg_index <= CFG_ONE_PATTERN;
		cfg_data  <= one_val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		one_pat = one_val;
		cfg_index <= CFG_ZERO_PATTERN;
		cfg_data  <= zero_val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		zero_pat = zero_val;
		cfg_valid <= 1'b0;
	endtask

	// Mostly in-range requests; the rest use the full index width
	function automatic led_request_t random_request();
		led_request_t item;
		int pick;
		pick       = $urandom_range(99);
		item.start = LIDX_W'($urandom_range(4095));
		item.stop  = LIDX_W'($urandom_range(4095));
		item.idx   = LIDX_W'($urandom_range(4095));
		item.col   = COLOR_W'($urandom_range(24'hFFFFFF));
		item.typed = 1'b0;
		item.want  = '0;
		if (pick < 30) begin
			item.req = REQ_WRITE;
			if ($urandom_range(99) < 85) begin
				item.stop  = LIDX_W'($urandom_range(LED_COUNT - 1));
				item.start = ($urandom_range(99) < 90) ?
					LIDX_W'($urandom_range(item.stop)) : LIDX_W'($urandom_range(4095));
			end
		end else if (pick < 95) begin
			if (pick < 62)
				item.req = REQ_READ;
			else
				item.req = REQ_EMIT;
			if ($urandom_range(99) < 85)
				item.idx = LIDX_W'($urandom_range(LED_COUNT - 1));
		end else begin
			item.req = REQ_CLEAR;
		end
		return item;
	endfunction

	// Receiver: random stalls and the field-by-field check of each beat
	always @(posedge clk) begin
		led_beat_t exp_beat;
		out_stall <= take_gap();
		if (arst_n && out_valid && !out_stall) begin
			if (due_beats.size() == 0) begin
				$error("result beat with nothing owed");
				error_count++;
			end else begin
				exp_beat = due_beats.pop_front();
				if (result_kind !== exp_beat.kind) begin
					$error("result_kind: expected %0d, got %0d", exp_beat.kind, result_kind);
					error_count++;
				end
				if (read_color !== exp_beat.rgb) begin
					$error("read_color: expected %h, got %h", exp_beat.rgb, read_color);
					error_count++;
				end
				if (line_byte !== exp_beat.lbyte) begin
					$error("line_byte: expected %h, got %h", exp_beat.lbyte, line_byte);
					error_count++;
				end
				if (last !== exp_beat.last) begin
					$error("last: expected %0d, got %0d", exp_beat.last, last);
					error_count++;
				end
			end
		end
	end

	// Watchdog: give up after too long without any beat on any channel
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
					(cfg_valid && cfg_ready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("TEST FAILED");
				$finish;
			end
		end
	end

	initial begin
		int r;
		int ph;
		int n;
		for (r = 0; r < LED_COUNT; r++)
			led_colors[r] = '0;

		// req, start, stop, index, colour, typed, typed answer
		directed_rows = '{
			'{REQ_READ,  12'd0,    12'd0,    12'd0,    24'h000000, 1'b1, 24'h000000},
			'{REQ_READ,  12'd0,    12'd0,    12'd63,   24'h000000, 1'b1, 24'h000000},
			'{REQ_READ,  12'd4095, 12'd4095, 12'd4095, 24'hFFFFFF, 1'b1, 24'h000000},
			'{REQ_EMIT,  12'd0,    12'd0,    12'd0,    24'h000000, 1'b0, 24'h000000},
			'{REQ_WRITE, 12'd0,    12'd63,   12'd0,    24'hFFFFFF, 1'b0, 24'h000000},
			'{REQ_READ,  12'd0,    12'd0,    12'd63,   24'h000000, 1'b1, 24'hFFFFFF},
			'{REQ_EMIT,  12'd0,    12'd0,    12'd5,    24'h000000, 1'b0, 24'h000000},
			'{REQ_WRITE, 12'd10,   12'd20,   12'd0,    24'h123456, 1'b0, 24'h000000},
			// stop one past the store: whole write dropped
			'{REQ_WRITE, 12'd30,   12'd64,   12'd0,    24'hAAAAAA, 1'b0, 24'h000000},
			'{REQ_READ,  12'd0,    12'd0,    12'd30,   24'h000000, 1'b1, 24'hFFFFFF},
			// start after stop: nothing written
			'{REQ_WRITE, 12'd40,   12'd30,   12'd0,    24'h000000, 1'b0, 24'h000000},
			'{REQ_READ,  12'd0,    12'd0,    12'd35,   24'h000000, 1'b1, 24'hFFFFFF},
			'{REQ_WRITE, 12'd4095, 12'd4095, 12'd0,    24'h000000, 1'b0, 24'h000000},
			'{REQ_WRITE, 12'd63,   12'd63,   12'd0,    24'h555555, 1'b0, 24'h000000},
			'{REQ_READ,  12'd0,    12'd0,    12'd63,   24'h000000, 1'b1, 24'h555555},
			'{REQ_READ,  12'd0,    12'd0,    12'd20,   24'h000000, 1'b1, 24'h123456},
			'{REQ_EMIT,  12'd0,    12'd0,    12'd15,   24'h000000, 1'b0, 24'h000000},
			// emit past the store sends an unlit LED
			'{REQ_EMIT,  12'd0,    12'd0,    12'd4095, 24'h000000, 1'b0, 24'h000000},
			'{REQ_READ,  12'd0,    12'd0,    12'd64,   24'h000000, 1'b1, 24'h000000},
			'{REQ_CLEAR, 12'd0,    12'd0,    12'd0,    24'h000000, 1'b0, 24'h000000},
			'{REQ_READ,  12'd0,    12'd0,    12'd15,   24'h000000, 1'b1, 24'h000000},
			'{REQ_EMIT,  12'd0,    12'd0,    12'd63,   24'h000000, 1'b0, 24'h000000},
			'{REQ_WRITE, 12'd0,    12'd0,    12'd0,    24'h800001, 1'b0, 24'h000000},
			'{REQ_EMIT,  12'd0,    12'd0,    12'd0,    24'h000000, 1'b0, 24'h000000},
			'{REQ_READ,  12'd0,    12'd0,    12'd0,    24'h000000, 1'b1, 24'h800001}
		};

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table under the reset patterns
		for (r = 0; r < ROWS; r++)
			drive_request(directed_rows[r]);

		// random mixes, one pattern pair per phase
		for (ph = 0; ph < PHASES; ph++) begin
			settle(SETTLE_GAP);
			case (ph)
				0: set_patterns(8'h00, 8'hFF);
				1: set_patterns(8'hFF, 8'h00);
				default: set_patterns(BYTE_W'($urandom_range(255)),
					BYTE_W'($urandom_range(255)));
			endcase
			steady = (ph == 2);
			for (n = 0; n < PHASE_ITEMS; n++) begin
				drive_request(random_request());
				if (ph == 1 && n == PHASE_ITEMS / 2)
					settle(0);
			end
			steady = 1'b0;
		end

		settle(SETTLE_GAP);
		if (error_count == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
